FILE: src/bpc_pkg.sv
package bpc_pkg;

    localparam int COEFF_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int RAW_W     = 24;
    localparam int TEMP_W    = 15;
    localparam int PRES_W    = 17;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS        = 3'd0,
        REG_OFFSET      = 3'd1,
        REG_SENS_TEMP   = 3'd2,
        REG_OFFSET_TEMP = 3'd3,
        REG_REF_TEMP    = 3'd4,
        REG_TEMP_SLOPE  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [COEFF_W-1:0] sens;
        logic [COEFF_W-1:0] offset;
        logic [COEFF_W-1:0] sens_temp;
        logic [COEFF_W-1:0] offset_temp;
        logic [COEFF_W-1:0] ref_temp;
        logic [COEFF_W-1:0] temp_slope;
    } t_coeffs;

    localparam int TEMP_REF     = 2000;   // 20.00 C
    localparam int TEMP_LOW_OFS = 3500;   // distance from 20.00 C down to -15.00 C
    localparam int OFF2_MUL     = 61;
    localparam int OFF3_MUL     = 15;
    localparam int TEMP_MIN     = -4000;
    localparam int TEMP_MAX     = 8500;
    localparam int PRES_MIN     = 1000;
    localparam int PRES_MAX     = 120000;

endpackage

FILE: src/bpc_cfg_regs.sv
module bpc_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bpc_pkg::COEFF_W-1:0]        i_cfg_data,
    output logic                               o_cfg_ready,
    output bpc_pkg::t_coeffs                   o_coeffs
);

    bpc_pkg::t_coeffs r_coeffs;

    assign o_cfg_ready = 1'b1;
    assign o_coeffs    = r_coeffs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs <= '0;
        end else if (i_cfg_valid) begin
            // indexes past the last register are dropped
            unique case (i_cfg_index)
                bpc_pkg::REG_SENS:        r_coeffs.sens        <= i_cfg_data;
                bpc_pkg::REG_OFFSET:      r_coeffs.offset      <= i_cfg_data;
                bpc_pkg::REG_SENS_TEMP:   r_coeffs.sens_temp   <= i_cfg_data;
                bpc_pkg::REG_OFFSET_TEMP: r_coeffs.offset_temp <= i_cfg_data;
                bpc_pkg::REG_REF_TEMP:    r_coeffs.ref_temp    <= i_cfg_data;
                bpc_pkg::REG_TEMP_SLOPE:  r_coeffs.temp_slope  <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

FILE: src/baro_pressure_compensation.sv
// Barometric pressure and temperature compensation, second order.
//
// Slave stream: one item per raw conversion pair (pressure and temperature,
// 24 bits each). Master stream: compensated temperature in 0.01 C, pressure
// in Pa and a flag set when either value was saturated to the sensor range.
// Config channel: six 16-bit calibration words, written by index while the
// block is idle (the user's duty; the block does not enforce it); it is always ready.
//
// Throughput: one item per clock while the receiver does not stall. The
// datapath is a 10-stage pipeline whose multipliers are each at most
// 25x25 bits; the final 24x43-bit pressure product is split into two
// partial products and summed in the following stage.
// An accepted item passes through stage registers 1 to 10 in order, and
// the output stage drives the master side.
// Reset (synchronous, active low) empties the pipeline and clears all
// calibration words to zero.
// When the receiver stalls, the result holds in the output stage and the
// stages behind it keep filling until no bubble is left; only then does
// s_axis_tready drop.
module baro_pressure_compensation (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [23:0] raw_pressure, [47:24] raw_temperature
    input  logic [bpc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [14:0] temperature, [31:15] pressure
    output logic [bpc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // [0] clamped
    output logic                                m_axis_tuser,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [bpc_pkg::COEFF_W-1:0]         i_cfg_data
);

    localparam int NSTG = 10;

    bpc_pkg::t_coeffs w_coeffs;

    bpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_coeffs    (w_coeffs)
    );

    // ---------------- pipeline control ----------------
    logic [NSTG:1] r_v;
    logic [NSTG:1] w_en;
    logic          w_s_acc;
    logic          w_m_acc;

    always_comb begin
        w_en[NSTG] = !r_v[NSTG] || m_axis_tready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[1];
    assign m_axis_tvalid = r_v[NSTG];
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;
    assign w_m_acc       = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[1]) begin
                r_v[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // ---------------- datapath ----------------
    // stage 1: dT
    logic signed [24:0] n_s1_dt, r_s1_dt;
    logic        [23:0] r_s1_d1;
    // stage 2: products with dT
    logic signed [41:0] n_s2_p6, n_s2_p4, n_s2_p3;
    logic signed [41:0] r_s2_p6, r_s2_p4, r_s2_p3;
    logic signed [49:0] n_s2_pdd, r_s2_pdd;
    logic        [23:0] r_s2_d1;
    // stage 3: first-order TEMP offset, OFF, SENS, T2
    logic signed [18:0] n_s3_a, r_s3_a, n_s3_am, r_s3_am;
    logic signed [19:0] n_s3_b, n_s3_bm, r_s3_bm;
    logic        [16:0] n_s3_t2, r_s3_t2;
    logic signed [37:0] n_s3_off, r_s3_off, n_s3_sens, r_s3_sens;
    logic        [23:0] r_s3_d1;
    // stage 4: squares, corrected TEMP
    logic signed [37:0] n_s4_aa, r_s4_aa;
    logic signed [39:0] n_s4_bb, r_s4_bb;
    logic signed [20:0] n_s4_temp, r_s4_temp;
    logic signed [37:0] r_s4_off, r_s4_sens;
    logic        [23:0] r_s4_d1;
    // stage 5: OFF2, SENS2, TEMP saturation
    logic        [41:0] n_s5_m61;
    logic        [41:0] n_s5_off2, r_s5_off2, n_s5_sens2, r_s5_sens2;
    logic        [14:0] n_s5_temp, r_s5_temp;
    logic               n_s5_thit, r_s5_thit;
    logic signed [37:0] r_s5_off, r_s5_sens;
    logic        [23:0] r_s5_d1;
    // stage 6: final OFF and SENS
    logic signed [42:0] n_s6_off, r_s6_off, n_s6_sens, r_s6_sens;
    logic        [23:0] r_s6_d1;
    logic        [14:0] r_s6_temp;
    logic               r_s6_thit;
    // stage 7: partial products of D1*SENS
    logic        [44:0] n_s7_pl, r_s7_pl;
    logic signed [46:0] n_s7_ph, r_s7_ph;
    logic signed [42:0] r_s7_off;
    logic        [14:0] r_s7_temp;
    logic               r_s7_thit;
    // stage 8: D1*SENS
    logic signed [67:0] n_s8_prod, r_s8_prod;
    logic signed [42:0] r_s8_off;
    logic        [14:0] r_s8_temp;
    logic               r_s8_thit;
    // stage 9: D1*SENS/2^21 - OFF
    logic signed [47:0] n_s9_q, r_s9_q;
    logic        [14:0] r_s9_temp;
    logic               r_s9_thit;
    // stage 10: P saturation, output register
    logic signed [32:0] w_p;
    logic        [16:0] n_out_pres;
    logic               n_out_phit;
    logic [bpc_pkg::OUT_TDATA_W-1:0] r_out_tdata;
    logic                            r_out_tuser;

    always_comb begin
        n_s1_dt = $signed({1'b0, s_axis_tdata[47:24]})
                - $signed({1'b0, w_coeffs.ref_temp, 8'h00});

        n_s2_p6  = r_s1_dt * $signed({1'b0, w_coeffs.temp_slope});
        n_s2_p4  = r_s1_dt * $signed({1'b0, w_coeffs.offset_temp});
        n_s2_p3  = r_s1_dt * $signed({1'b0, w_coeffs.sens_temp});
        n_s2_pdd = r_s1_dt * r_s1_dt;

        // TEMP - 2000 = floor(dT*C6 / 2^23)
        n_s3_a  = r_s2_p6[41:23];
        n_s3_b  = $signed({n_s3_a[18], n_s3_a}) + 20'(bpc_pkg::TEMP_LOW_OFS);
        // zero the terms that do not apply so their squares vanish
        n_s3_am = n_s3_a[18] ? n_s3_a : '0;
        n_s3_bm = n_s3_b[19] ? n_s3_b : '0;
        n_s3_t2 = n_s3_a[18] ? r_s2_pdd[47:31] : '0;
        n_s3_off  = $signed({5'b0, w_coeffs.offset, 17'b0})
                  + $signed({{2{r_s2_p4[41]}}, r_s2_p4[41:6]});
        n_s3_sens = $signed({6'b0, w_coeffs.sens, 16'b0})
                  + $signed({{3{r_s2_p3[41]}}, r_s2_p3[41:7]});

        n_s4_aa   = r_s3_am * r_s3_am;
        n_s4_bb   = r_s3_bm * r_s3_bm;
        n_s4_temp = $signed({{2{r_s3_a[18]}}, r_s3_a}) + 21'(bpc_pkg::TEMP_REF)
                  - $signed({4'b0, r_s3_t2});

        n_s5_m61   = {6'b0, r_s4_aa[35:0]} * 42'(bpc_pkg::OFF2_MUL);
        n_s5_off2  = {4'b0, n_s5_m61[41:4]}
                   + {6'b0, r_s4_bb[35:0]} * 42'(bpc_pkg::OFF3_MUL);
        n_s5_sens2 = {5'b0, r_s4_aa[35:0], 1'b0} + {3'b0, r_s4_bb[35:0], 3'b0};
        priority if (r_s4_temp < 21'(bpc_pkg::TEMP_MIN)) begin
            n_s5_temp = 15'(bpc_pkg::TEMP_MIN);
            n_s5_thit = 1'b1;
        end else if (r_s4_temp > 21'(bpc_pkg::TEMP_MAX)) begin
            n_s5_temp = 15'(bpc_pkg::TEMP_MAX);
            n_s5_thit = 1'b1;
        end else begin
            n_s5_temp = r_s4_temp[14:0];
            n_s5_thit = 1'b0;
        end

        n_s6_off  = $signed({{5{r_s5_off[37]}}, r_s5_off}) - $signed({1'b0, r_s5_off2});
        n_s6_sens = $signed({{5{r_s5_sens[37]}}, r_s5_sens}) - $signed({1'b0, r_s5_sens2});

        // split SENS into an unsigned low half and a signed high half
        n_s7_pl = {21'b0, r_s6_d1} * {24'b0, r_s6_sens[20:0]};
        n_s7_ph = $signed({1'b0, r_s6_d1}) * $signed(r_s6_sens[42:21]);

        n_s8_prod = $signed({r_s7_ph, 21'b0}) + $signed({23'b0, r_s7_pl});

        n_s9_q = $signed({r_s8_prod[67], r_s8_prod[67:21]})
               - $signed({{5{r_s8_off[42]}}, r_s8_off});

        w_p = r_s9_q[47:15];
        priority if (w_p < 33'(bpc_pkg::PRES_MIN)) begin
            n_out_pres = 17'(bpc_pkg::PRES_MIN);
            n_out_phit = 1'b1;
        end else if (w_p > 33'(bpc_pkg::PRES_MAX)) begin
            n_out_pres = 17'(bpc_pkg::PRES_MAX);
            n_out_phit = 1'b1;
        end else begin
            n_out_pres = w_p[16:0];
            n_out_phit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s1_dt <= n_s1_dt;
            r_s1_d1 <= s_axis_tdata[23:0];
        end
        if (w_en[2]) begin
            r_s2_p6  <= n_s2_p6;
            r_s2_p4  <= n_s2_p4;
            r_s2_p3  <= n_s2_p3;
            r_s2_pdd <= n_s2_pdd;
            r_s2_d1  <= r_s1_d1;
        end
        if (w_en[3]) begin
            r_s3_a    <= n_s3_a;
            r_s3_am   <= n_s3_am;
            r_s3_bm   <= n_s3_bm;
            r_s3_t2   <= n_s3_t2;
            r_s3_off  <= n_s3_off;
            r_s3_sens <= n_s3_sens;
            r_s3_d1   <= r_s2_d1;
        end
        if (w_en[4]) begin
            r_s4_aa   <= n_s4_aa;
            r_s4_bb   <= n_s4_bb;
            r_s4_temp <= n_s4_temp;
            r_s4_off  <= r_s3_off;
            r_s4_sens <= r_s3_sens;
            r_s4_d1   <= r_s3_d1;
        end
        if (w_en[5]) begin
            r_s5_off2  <= n_s5_off2;
            r_s5_sens2 <= n_s5_sens2;
            r_s5_temp  <= n_s5_temp;
            r_s5_thit  <= n_s5_thit;
            r_s5_off   <= r_s4_off;
            r_s5_sens  <= r_s4_sens;
            r_s5_d1    <= r_s4_d1;
        end
        if (w_en[6]) begin
            r_s6_off  <= n_s6_off;
            r_s6_sens <= n_s6_sens;
            r_s6_d1   <= r_s5_d1;
            r_s6_temp <= r_s5_temp;
            r_s6_thit <= r_s5_thit;
        end
        if (w_en[7]) begin
            r_s7_pl   <= n_s7_pl;
            r_s7_ph   <= n_s7_ph;
            r_s7_off  <= r_s6_off;
            r_s7_temp <= r_s6_temp;
            r_s7_thit <= r_s6_thit;
        end
        if (w_en[8]) begin
            r_s8_prod <= n_s8_prod;
            r_s8_off  <= r_s7_off;
            r_s8_temp <= r_s7_temp;
            r_s8_thit <= r_s7_thit;
        end
        if (w_en[9]) begin
            r_s9_q    <= n_s9_q;
            r_s9_temp <= r_s8_temp;
            r_s9_thit <= r_s8_thit;
        end
        if (w_en[10]) begin
            r_out_tdata <= {n_out_pres, r_s9_temp};
            r_out_tuser <= r_s9_thit || n_out_phit;
        end
    end

    assign m_axis_tdata = r_out_tdata;
    assign m_axis_tuser = r_out_tuser;

    // ---------------- assertions ----------------
    // an empty output stage must leave room for a new item
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with an empty output stage");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc && !w_m_acc) |=> ($countones(r_v) == $past($countones(r_v)) + 1))
        else $error("accepted item not tracked in the pipeline");

    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_s_acc && w_m_acc) |=> ($countones(r_v) == $past($countones(r_v)) - 1))
        else $error("delivered item not removed from the pipeline");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_acc == w_m_acc) |=> ($countones(r_v) == $past($countones(r_v))))
        else $error("pipeline item count changed without a handshake");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

FILE: tb/sv/tb_baro_pressure_compensation.sv
`timescale 1ns / 1ps

module tb_baro_pressure_compensation;

    localparam int NUM_COEFFS      = int'(bpc_pkg::REG_TEMP_SLOPE) + 1;
    localparam int RAW_MAX         = (1 << bpc_pkg::RAW_W) - 1;
    localparam int TEMP_COLD       = bpc_pkg::TEMP_REF - bpc_pkg::TEMP_LOW_OFS;   // -15.00 C
    localparam int SETTLE_CYCLES   = 12;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int NUM_PHASES      = 6;
    localparam int MAX_REPORTS     = 10;

    // Indexes past the last calibration word; the block must ignore them
    localparam logic [bpc_pkg::CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [bpc_pkg::CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

    // Datasheet-like calibration, order C1..C6 from the top
    localparam bpc_pkg::t_coeffs TYP_CAL = {16'd46372, 16'd43981, 16'd29059,
                                            16'd27842, 16'd31553, 16'd28165};

    typedef struct packed {
        logic signed [bpc_pkg::TEMP_W-1:0] temp;
        logic [bpc_pkg::PRES_W-1:0]        pres;
        logic                              clamped;
    } t_comp_reading;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_valid   = 1'b0;
    logic                            s_ready;
    logic [bpc_pkg::IN_TDATA_W-1:0]  s_data    = '0;
    logic                            m_valid;
    logic                            m_ready   = 1'b0;
    logic [bpc_pkg::OUT_TDATA_W-1:0] m_data;
    logic                            m_user;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [bpc_pkg::COEFF_W-1:0]     cfg_data  = '0;

    logic [bpc_pkg::IN_TDATA_W-1:0]  raw_backlog [$];
    t_comp_reading                   comp_backlog [$];
    logic [bpc_pkg::COEFF_W-1:0]     cal [NUM_COEFFS];
    int                              gap_pct    = 33;
    int                              mismatches = 0;

    baro_pressure_compensation i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Second-order compensation in 64-bit integers; >>> on signed values floors
    function automatic t_comp_reading compensate(
        input logic [bpc_pkg::RAW_W-1:0] d1_raw,
        input logic [bpc_pkg::RAW_W-1:0] d2_raw);
        longint c1, c2, c3, c4, c5, c6;
        longint d1, dt, temp, off, sens, t2, off2, sens2, a, b, p;
        t_comp_reading r;
        c1 = longint'(cal[bpc_pkg::REG_SENS]);
        c2 = longint'(cal[bpc_pkg::REG_OFFSET]);
        c3 = longint'(cal[bpc_pkg::REG_SENS_TEMP]);
        c4 = longint'(cal[bpc_pkg::REG_OFFSET_TEMP]);
        c5 = longint'(cal[bpc_pkg::REG_REF_TEMP]);
        c6 = longint'(cal[bpc_pkg::REG_TEMP_SLOPE]);
        d1 = longint'(d1_raw);
        dt = longint'(d2_raw) - c5 * 256;
        temp = longint'(bpc_pkg::TEMP_REF) + ((dt * c6) >>> 23);
        off  = c2 * 131072 + ((c4 * dt) >>> 6);
        sens = c1 * 65536 + ((c3 * dt) >>> 7);
        t2 = 0;
        off2 = 0;
        sens2 = 0;
        // both low-temperature tests look at TEMP before T2 comes off
        if (temp < longint'(bpc_pkg::TEMP_REF)) begin
            a = temp - longint'(bpc_pkg::TEMP_REF);
            t2 = (dt * dt) >>> 31;
            off2 = (longint'(bpc_pkg::OFF2_MUL) * a * a) >>> 4;
            sens2 = 2 * a * a;
        end
        if (temp < longint'(TEMP_COLD)) begin
            b = temp - longint'(TEMP_COLD);
            off2 += longint'(bpc_pkg::OFF3_MUL) * b * b;
            sens2 += 8 * b * b;
        end
        temp -= t2;
        off -= off2;
        sens -= sens2;
        p = (((d1 * sens) >>> 21) - off) >>> 15;

        r.clamped = 1'b0;
        if (temp < longint'(bpc_pkg::TEMP_MIN)) begin
            temp = longint'(bpc_pkg::TEMP_MIN);
            r.clamped = 1'b1;
        end else if (temp > longint'(bpc_pkg::TEMP_MAX)) begin
            temp = longint'(bpc_pkg::TEMP_MAX);
            r.clamped = 1'b1;
        end
        if (p < longint'(bpc_pkg::PRES_MIN)) begin
            p = longint'(bpc_pkg::PRES_MIN);
            r.clamped = 1'b1;
        end else if (p > longint'(bpc_pkg::PRES_MAX)) begin
            p = longint'(bpc_pkg::PRES_MAX);
            r.clamped = 1'b1;
        end
        r.temp = temp[bpc_pkg::TEMP_W-1:0];
        r.pres = p[bpc_pkg::PRES_W-1:0];
        return r;
    endfunction

    // Present the next item only once the current one is taken
    always @(posedge clk) begin
        if (!rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (raw_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
                s_valid <= 1'b1;
                s_data  <= raw_backlog.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        m_ready <= ($urandom_range(99) >= gap_pct);
    end

    always @(posedge clk) begin : monitor
        t_comp_reading want;
        t_comp_reading got;
        if (rst_n) begin
            if (cfg_valid && cfg_ready && cfg_index <= bpc_pkg::REG_TEMP_SLOPE)
                cal[cfg_index] = cfg_data;
            if (s_valid && s_ready)
                comp_backlog.push_back(compensate(
                    s_data[bpc_pkg::RAW_W-1:0],
                    s_data[2*bpc_pkg::RAW_W-1:bpc_pkg::RAW_W]));
            if (m_valid && m_ready) begin
                got.temp    = m_data[bpc_pkg::TEMP_W-1:0];
                got.pres    = m_data[bpc_pkg::TEMP_W+bpc_pkg::PRES_W-1:bpc_pkg::TEMP_W];
                got.clamped = m_user;
                if (comp_backlog.size() == 0) begin
                    if (mismatches < MAX_REPORTS)
                        $display("%0t: unexpected item temp %0d pres %0d clamped %0b",
                                 $realtime, got.temp, got.pres, got.clamped);
                    mismatches++;
                end else begin
                    want = comp_backlog.pop_front();
                    if (got != want) begin
                        if (mismatches < MAX_REPORTS)
                            $display("%0t: expected %0d %0d %0b, got %0d %0d %0b",
                                     $realtime, want.temp, want.pres, want.clamped,
                                     got.temp, got.pres, got.clamped);
                        mismatches++;
                    end
                end
            end
        end
    end

    task automatic queue_pair(input int d1, input int d2);
        raw_backlog.push_back({d2[bpc_pkg::RAW_W-1:0], d1[bpc_pkg::RAW_W-1:0]});
    endtask

    // Hold until nothing is in flight, then let the pipeline run dry
    task automatic wait_quiet();
        do @(negedge clk);
        while (raw_backlog.size() != 0 || s_valid || comp_backlog.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leaves valid high; the caller drops it after the last write
    task automatic cfg_put(input logic [bpc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bpc_pkg::COEFF_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_cal(input bpc_pkg::t_coeffs cw);
        cfg_put(bpc_pkg::REG_SENS, cw.sens);
        cfg_put(bpc_pkg::REG_OFFSET, cw.offset);
        cfg_put(bpc_pkg::REG_SENS_TEMP, cw.sens_temp);
        cfg_put(bpc_pkg::REG_OFFSET_TEMP, cw.offset_temp);
        cfg_put(bpc_pkg::REG_REF_TEMP, cw.ref_temp);
        cfg_put(bpc_pkg::REG_TEMP_SLOPE, cw.temp_slope);
        // out-of-range indexes go last so any aliasing would corrupt a live word
        cfg_put(IDX_SPARE_LO, 16'($urandom));
        cfg_put(IDX_SPARE_HI, 16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        bpc_pkg::t_coeffs cw;
        longint v;
        int base;
        logic [bpc_pkg::RAW_W-1:0] d1, d2;

        for (int k = 0; k < NUM_COEFFS; k++)
            cal[k] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // calibration words still at their reset value
        queue_pair(0, 0);
        queue_pair(RAW_MAX, RAW_MAX);
        queue_pair(6465444, 8077636);
        wait_quiet();

        load_cal(TYP_CAL);
        base = int'(TYP_CAL.ref_temp) * 256;
        queue_pair(6465444, 8077636);
        queue_pair(0, 0);
        queue_pair(RAW_MAX, RAW_MAX);
        queue_pair(0, RAW_MAX);
        queue_pair(RAW_MAX, 0);
        queue_pair(6465444, base);                // zero delta
        queue_pair(6465444, base - 1);            // floor drops TEMP just under 20 C
        queue_pair(6465444, base + 148900);       // warm, first order only
        queue_pair(6465444, base - 297800);       // cool, second-order correction
        queue_pair(6465444, base - 1191000);      // cold, extra correction below -15 C
        queue_pair(6465444, base - 1780000);      // first-order TEMP close to the low temperature limit
        queue_pair(6465444, base - 2000000);      // temperature saturates low
        queue_pair(6465444, base + 2000000);      // temperature saturates high
        queue_pair(3900000, base);                // pressure saturates low
        queue_pair(7000000, base);
        queue_pair(8000000, base);                // pressure saturates high
        wait_quiet();

        load_cal('1);
        queue_pair(0, 0);
        queue_pair(RAW_MAX, RAW_MAX);
        queue_pair(6465444, 8077636);
        wait_quiet();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            unique case (ph)
                0: cw = TYP_CAL;
                4: cw = '1;
                5: begin
                    for (int k = 0; k < NUM_COEFFS; k++)
                        cw[k*bpc_pkg::COEFF_W +: bpc_pkg::COEFF_W] = 16'($urandom);
                end
                default: begin
                    for (int k = 0; k < NUM_COEFFS; k++)
                        cw[k*bpc_pkg::COEFF_W +: bpc_pkg::COEFF_W] =
                            TYP_CAL[k*bpc_pkg::COEFF_W +: bpc_pkg::COEFF_W]
                            + 16'($urandom_range(8191)) - 16'd4096;
                end
            endcase
            gap_pct = (ph == 0) ? 0 : 33;
            load_cal(cw);
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(99) < 15) begin
                    d1 = 24'($urandom);
                    d2 = 24'($urandom);
                end else begin
                    // plausible readings spanning both corrections and both clamps
                    d1 = 24'($urandom_range(7500000, 3500000));
                    v = longint'(cw.ref_temp) * 256
                        + longint'($urandom_range(4600000)) - 2300000;
                    if (v < 0)
                        d2 = '0;
                    else if (v > RAW_MAX)
                        d2 = RAW_MAX;
                    else
                        d2 = v[bpc_pkg::RAW_W-1:0];
                end
                queue_pair(int'(d1), int'(d2));
            end
            wait_quiet();
        end

        if (mismatches == 0 && comp_backlog.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
